/* rtl/srv_pkg.sv */
// ----------------------------------------------------------------------------
// srv_pkg
// shared constants and stage records for the snell refraction pipeline
// ----------------------------------------------------------------------------
package srv_pkg;

    // pipeline register stages from the input register to the last result stage
    localparam int unsigned SRV_DEPTH = 117;

    localparam logic [1:0] ST_REFR = 2'd0;
    localparam logic [1:0] ST_TIR  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic signed [19:0] OUT_MAX = 20'sd524287;
    localparam logic signed [19:0] OUT_MIN = -20'sd524288;

    // front end: magnitudes of the direction, normal and ratio
    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [2:0][15:0] nrm;
        logic [15:0]      ratio;
    } t_front;

    // through the first root: magnitudes scaled by the normalising shift
    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][31:0] msh;
        logic [2:0][15:0] nrm;
        logic [15:0]      ratio;
    } t_side_a;

    // through the dividers and the cosine arithmetic
    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][15:0] nrm;
        logic [15:0]      ratio;
    } t_side_b;

    // through the second root
    typedef struct packed {
        logic             zero;
        logic             tir;
        logic [2:0][15:0] nrm;
        logic [15:0]      ratio;
        logic [2:0][39:0] diff;
    } t_side_c;

    typedef struct packed {
        logic [1:0]       st;
        logic [2:0][19:0] v;
    } t_result;

endpackage

/* rtl/snell_refraction_vector.sv */
// ----------------------------------------------------------------------------
// snell_refraction_vector
// refracts one ray direction at a surface per clock unless the master side stalls, fully pipelined
// ----------------------------------------------------------------------------
// slave side: one request holds the Q16.16 direction, the Q2.14 unit normal and
// the unsigned Q2.14 index ratio. master side: the Q6.14 refracted direction
// in tdata and the status in tuser (refracted, total internal reflection or
// zero-length direction; the vector is zero for the last two).
// the input register takes a request at the accepting edge; it then passes
// 116 further pipeline stages (two 32-step square roots, three 32-step
// restoring dividers in parallel and the fixed-point arithmetic between
// them) and the output register on its way to the master side.
// throughput: one request per cycle while s_axis_tready is high, in order.
// reset clears every valid bit, the output and skid valid flags among them;
// no result is pending afterwards.
// when the master side stalls, the held result stays in the output register
// and one more result enters the skid register; only then does s_axis_tready
// fall and the whole pipeline hold. nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module snell_refraction_vector (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // refracted_x, refracted_y, refracted_z, zero fill
    output logic [63:0]  m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);
    import srv_pkg::*;

    function automatic logic [63:0] f_mag64(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        return m;
    endfunction

    // shift right by k, round to nearest, ties away from zero
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] x,
                                                 input int unsigned k);
        logic [63:0] m;
        m = (f_mag64(x) + (64'd1 << (k - 1))) >> k;
        return x[63] ? $signed(-m) : $signed(m);
    endfunction

    // one digit of the restoring square root: {rem, root}
    function automatic logic [65:0] f_sqrt_step(input logic [33:0] rem,
                                                input logic [31:0] root,
                                                input logic [1:0]  b);
        logic [35:0] t;
        logic [35:0] trial;
        logic [33:0] nr;
        logic [31:0] nq;
        t     = {rem, b};
        trial = {2'b00, root, 2'b01};
        if (t >= trial) begin
            nr = 34'(t - trial);
            nq = {root[30:0], 1'b1};
        end else begin
            nr = t[33:0];
            nq = {root[30:0], 1'b0};
        end
        return {nr, nq};
    endfunction

    function automatic t_side_a f_side_a(input t_front f, input logic [4:0] h);
        t_side_a s;
        s.zero  = f.zero;
        s.neg   = f.neg;
        s.nrm   = f.nrm;
        s.ratio = f.ratio;
        for (int i = 0; i < 3; i++) begin
            s.msh[i] = f.mag[i] << h;
        end
        return s;
    endfunction

    logic                 en;
    logic [SRV_DEPTH-1:0] r_vld;
    logic                 fin_v;
    logic                 r_ov;
    logic                 r_sk_v;
    t_result              r_od;
    t_result              r_sk_d;

    assign en            = ~r_sk_v;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[SRV_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // ---------------- front end and normalising shift ----------------
    t_front      w_f;
    t_front      r1_f, r2_f, r3_f, r4_f, r5_f;
    logic [2:0][63:0] r2_sq;
    logic [63:0] r3_len;
    logic [63:0] r4_x, r5_x;
    logic [4:0]  r4_h, r5_h;
    logic [63:0] w_x4, w_x5;
    logic [4:0]  w_h4, w_h5;

    always_comb begin
        w_f.zero  = (s_axis_tdata[95:0] == 96'd0);
        w_f.ratio = s_axis_tdata[159:144];
        for (int i = 0; i < 3; i++) begin
            w_f.neg[i] = s_axis_tdata[32*i+31];
            w_f.mag[i] = w_f.neg[i] ? 32'(-s_axis_tdata[32*i +: 32])
                                    : s_axis_tdata[32*i +: 32];
            w_f.nrm[i] = s_axis_tdata[96+16*i +: 16];
        end
    end

    always_comb begin
        w_x4 = r3_len;
        w_h4 = 5'd0;
        if (w_x4[63:32] == 32'd0) begin
            w_x4 = w_x4 << 32;
            w_h4 = w_h4 + 5'd16;
        end
        if (w_x4[63:48] == 16'd0) begin
            w_x4 = w_x4 << 16;
            w_h4 = w_h4 + 5'd8;
        end
        w_x5 = r4_x;
        w_h5 = r4_h;
        if (w_x5[63:56] == 8'd0) begin
            w_x5 = w_x5 << 8;
            w_h5 = w_h5 + 5'd4;
        end
        if (w_x5[63:60] == 4'd0) begin
            w_x5 = w_x5 << 4;
            w_h5 = w_h5 + 5'd2;
        end
        if (w_x5[63:62] == 2'd0) begin
            w_x5 = w_x5 << 2;
            w_h5 = w_h5 + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_f <= w_f;
            r2_f <= r1_f;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 64'(r1_f.mag[i]) * 64'(r1_f.mag[i]);
            end
            r3_f   <= r2_f;
            r3_len <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r4_f   <= r3_f;
            r4_x   <= w_x4;
            r4_h   <= w_h4;
            r5_f   <= r4_f;
            r5_x   <= w_x5;
            r5_h   <= w_h5;
        end
    end

    // ---------------- length root, one digit per stage ----------------
    t_side_a     r_qa_s    [0:31];
    logic [63:0] r_qa_x    [0:31];
    logic [33:0] r_qa_rem  [0:31];
    logic [31:0] r_qa_root [0:31];

    for (genvar k = 0; k < 32; k++) begin : g_sqa
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_x;
        t_side_a     w_s;
        logic [65:0] w_nx;
        if (k == 0) begin : g_first
            always_comb begin
                w_rem  = '0;
                w_root = '0;
                w_x    = r5_x;
                w_s    = f_side_a(r5_f, r5_h);
            end
        end else begin : g_next
            always_comb begin
                w_rem  = r_qa_rem[k-1];
                w_root = r_qa_root[k-1];
                w_x    = r_qa_x[k-1];
                w_s    = r_qa_s[k-1];
            end
        end
        assign w_nx = f_sqrt_step(w_rem, w_root, w_x[63-2*k -: 2]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qa_rem[k]  <= w_nx[65:32];
                r_qa_root[k] <= w_nx[31:0];
                r_qa_x[k]    <= w_x;
                r_qa_s[k]    <= w_s;
            end
        end
    end

    // ---------------- unit direction, restoring division ----------------
    logic [2:0][62:0] r_p_num;
    logic [31:0]      r_p_d;
    t_side_b          r_p_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p_num[i] <= {1'b0, r_qa_s[31].msh[i], 30'd0}
                            + {32'd0, r_qa_root[31][31:1]};
            end
            r_p_d <= r_qa_root[31];
            r_p_s <= '{zero: r_qa_s[31].zero, neg: r_qa_s[31].neg,
                       nrm: r_qa_s[31].nrm, ratio: r_qa_s[31].ratio};
        end
    end

    logic [2:0][31:0] r_dv_rem [0:31];
    logic [2:0][31:0] r_dv_q   [0:31];
    logic [2:0][31:0] r_dv_lo  [0:31];
    logic [31:0]      r_dv_d   [0:31];
    t_side_b          r_dv_s   [0:31];

    for (genvar k = 0; k < 32; k++) begin : g_div
        logic [2:0][31:0] w_rem, w_q, w_lo, n_rem, n_q;
        logic [31:0]      w_d;
        t_side_b          w_s;
        logic [32:0]      w_t [0:2];
        if (k == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_rem[i] = {1'b0, r_p_num[i][62:32]};
                    w_lo[i]  = r_p_num[i][31:0];
                end
                w_q = '0;
                w_d = r_p_d;
                w_s = r_p_s;
            end
        end else begin : g_next
            always_comb begin
                w_rem = r_dv_rem[k-1];
                w_q   = r_dv_q[k-1];
                w_lo  = r_dv_lo[k-1];
                w_d   = r_dv_d[k-1];
                w_s   = r_dv_s[k-1];
            end
        end
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_t[i] = {w_rem[i], w_lo[i][31-k]};
                if (w_t[i] >= {1'b0, w_d}) begin
                    n_rem[i] = 32'(w_t[i] - {1'b0, w_d});
                    n_q[i]   = {w_q[i][30:0], 1'b1};
                end else begin
                    n_rem[i] = w_t[i][31:0];
                    n_q[i]   = {w_q[i][30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[k] <= n_rem;
                r_dv_q[k]   <= n_q;
                r_dv_lo[k]  <= w_lo;
                r_dv_d[k]   <= w_d;
                r_dv_s[k]   <= w_s;
            end
        end
    end

    // ---------------- cosine, discriminant ----------------
    logic [2:0][32:0] r_d1_u, r_d2_u, r_d3_u, r_d4_u, r_d5_u, r_d6_u;
    t_side_b          r_d1_s, r_d2_s, r_d3_s, r_d4_s, r_d5_s, r_d6_s;
    logic [2:0][48:0] r_d2_un;
    logic signed [50:0] r_d3_acc;
    logic signed [36:0] r_d4_c;
    logic [32:0]      r_d5_ac;
    logic [2:0][52:0] r_d5_nc;
    logic [31:0]      r_d5_rr, r_d6_rr, r_d7_rr, r_d8_rr, r_d9_rr;
    logic [33:0]      r_d6_ah2;
    logic [32:0]      r_d6_ahal;
    logic [31:0]      r_d6_al2;
    logic [2:0][38:0] r_d6_ncr;
    logic [63:0]      r_d7_sum;
    t_side_c          r_d7_s, r_d8_s, r_d9_s, r_d10_s, r_d11_s, r_d12_s;
    logic signed [33:0] r_d8_om;
    logic [31:0]      r_d9_mom;
    logic             r_d9_neg, r_d10_neg;
    logic [63:0]      r_d10_pm;
    logic signed [39:0] r_d11_disc;
    logic [63:0]      r_d12_x;

    logic [63:0]      w_c2sum;
    logic [63:0]      w_pmr;
    logic [63:0]      w_rc;
    logic [63:0]      w_ac;
    t_side_c          w_s7;
    t_side_c          w_s12;

    always_comb begin
        w_c2sum  = r_d7_sum + 64'h0000_0000_8000_0000;
        w_pmr    = (r_d10_pm + 64'd33554432) >> 26;
        w_rc     = 64'(f_rnd(64'(r_d3_acc), 14));
        w_ac     = f_mag64(64'(r_d4_c));
        w_s7.zero  = r_d6_s.zero;
        w_s7.tir   = 1'b0;
        w_s7.nrm   = r_d6_s.nrm;
        w_s7.ratio = r_d6_s.ratio;
        for (int i = 0; i < 3; i++) begin
            w_s7.diff[i] = 40'($signed(r_d6_u[i])) - 40'($signed(r_d6_ncr[i]));
        end
        w_s12     = r_d11_s;
        w_s12.tir = r_d11_disc[39] | (r_d11_disc == 40'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_d1_u[i] <= r_dv_s[31].neg[i] ? 33'(-{1'b0, r_dv_q[31][i]})
                                               : {1'b0, r_dv_q[31][i]};
                r_d2_un[i] <= 49'($signed(r_d1_u[i]) * $signed(r_d1_s.nrm[i]));
                r_d5_nc[i] <= 53'($signed(r_d4_c) * $signed(r_d4_s.nrm[i]));
                r_d6_ncr[i] <= 39'(f_rnd(64'($signed(r_d5_nc[i])), 14));
            end
            r_d1_s <= r_dv_s[31];
            r_d2_u <= r_d1_u;
            r_d2_s <= r_d1_s;
            r_d3_u <= r_d2_u;
            r_d3_s <= r_d2_s;
            r_d3_acc <= 51'($signed(r_d2_un[0])) + 51'($signed(r_d2_un[1]))
                      + 51'($signed(r_d2_un[2]));
            r_d4_u <= r_d3_u;
            r_d4_s <= r_d3_s;
            r_d4_c <= $signed(w_rc[36:0]);
            r_d5_u <= r_d4_u;
            r_d5_s <= r_d4_s;
            r_d5_ac <= w_ac[32:0];
            r_d5_rr <= 32'(r_d4_s.ratio) * 32'(r_d4_s.ratio);
            r_d6_u <= r_d5_u;
            r_d6_s <= r_d5_s;
            r_d6_rr <= r_d5_rr;
            r_d6_ah2  <= 34'(r_d5_ac[32:16]) * 34'(r_d5_ac[32:16]);
            r_d6_ahal <= 33'(r_d5_ac[32:16]) * 33'(r_d5_ac[15:0]);
            r_d6_al2  <= 32'(r_d5_ac[15:0]) * 32'(r_d5_ac[15:0]);
            r_d7_s   <= w_s7;
            r_d7_rr  <= r_d6_rr;
            r_d7_sum <= {r_d6_ah2[31:0], 32'd0} + {14'd0, r_d6_ahal, 17'd0}
                      + {32'd0, r_d6_al2};
            r_d8_s  <= r_d7_s;
            r_d8_rr <= r_d7_rr;
            r_d8_om <= 34'sd268435456 - $signed({2'b00, w_c2sum[63:32]});
            r_d9_s   <= r_d8_s;
            r_d9_rr  <= r_d8_rr;
            r_d9_neg <= r_d8_om[33];
            r_d9_mom <= r_d8_om[33] ? 32'(-r_d8_om) : r_d8_om[31:0];
            r_d10_s   <= r_d9_s;
            r_d10_neg <= r_d9_neg;
            r_d10_pm  <= 64'(r_d9_rr) * 64'(r_d9_mom);
            r_d11_s   <= r_d10_s;
            r_d11_disc <= r_d10_neg ? $signed(40'd1073741824 + {2'b00, w_pmr[37:0]})
                                    : $signed(40'd1073741824 - {2'b00, w_pmr[37:0]});
            r_d12_s      <= w_s12;
            r_d12_x      <= {r_d11_disc[37:0], 26'd0};
        end
    end

    // ---------------- discriminant root ----------------
    t_side_c     r_qc_s    [0:31];
    logic [63:0] r_qc_x    [0:31];
    logic [33:0] r_qc_rem  [0:31];
    logic [31:0] r_qc_root [0:31];

    for (genvar k = 0; k < 32; k++) begin : g_sqc
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_x;
        t_side_c     w_s;
        logic [65:0] w_nx;
        if (k == 0) begin : g_first
            always_comb begin
                w_rem  = '0;
                w_root = '0;
                w_x    = r_d12_x;
                w_s    = r_d12_s;
            end
        end else begin : g_next
            always_comb begin
                w_rem  = r_qc_rem[k-1];
                w_root = r_qc_root[k-1];
                w_x    = r_qc_x[k-1];
                w_s    = r_qc_s[k-1];
            end
        end
        assign w_nx = f_sqrt_step(w_rem, w_root, w_x[63-2*k -: 2]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qc_rem[k]  <= w_nx[65:32];
                r_qc_root[k] <= w_nx[31:0];
                r_qc_x[k]    <= w_x;
                r_qc_s[k]    <= w_s;
            end
        end
    end

    // ---------------- refracted vector ----------------
    logic [2:0][56:0] r_f1_p1;
    logic [2:0][48:0] r_f1_p2;
    logic [2:0][57:0] r_f2_v;
    logic             r_f1_zero, r_f1_tir, r_f2_zero, r_f2_tir;
    t_result          r_f3;
    t_result          w_f3;
    logic signed [63:0] w_rv [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rv[i] = f_rnd(64'($signed(r_f2_v[i])), 30);
            if (r_f2_zero || r_f2_tir) begin
                w_f3.v[i] = '0;
            end else if (w_rv[i] > 64'(OUT_MAX)) begin
                w_f3.v[i] = OUT_MAX;
            end else if (w_rv[i] < 64'(OUT_MIN)) begin
                w_f3.v[i] = OUT_MIN;
            end else begin
                w_f3.v[i] = w_rv[i][19:0];
            end
        end
        if (r_f2_zero) begin
            w_f3.st = ST_ZERO;
        end else if (r_f2_tir) begin
            w_f3.st = ST_TIR;
        end else begin
            w_f3.st = ST_REFR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_f1_p1[i] <= 57'($signed({1'b0, r_qc_s[31].ratio})
                                  * $signed(r_qc_s[31].diff[i]));
                r_f1_p2[i] <= 49'($signed(r_qc_s[31].nrm[i])
                                  * $signed({1'b0, r_qc_root[31]}));
                r_f2_v[i]  <= 58'($signed(r_f1_p1[i]))
                            - (58'($signed(r_f1_p2[i])) <<< 2);
            end
            r_f1_zero <= r_qc_s[31].zero;
            r_f1_tir  <= r_qc_s[31].tir;
            r_f2_zero <= r_f1_zero;
            r_f2_tir  <= r_f1_tir;
            r_f3      <= w_f3;
        end
    end

    // ---------------- output register and skid ----------------
    assign fin_v = r_vld[SRV_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (m_axis_tready) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_ov && !m_axis_tready) begin
            r_sk_v <= fin_v;
        end else begin
            r_ov <= fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (m_axis_tready) begin
                r_od <= r_sk_d;
            end
        end else if (r_ov && !m_axis_tready) begin
            r_sk_d <= r_f3;
        end else begin
            r_od <= r_f3;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_od.v[2], r_od.v[1], r_od.v[0]};
    assign m_axis_tuser  = r_od.st;

endmodule
